// File: hw/rtl/integer_to_ascii_field_formatter_core_assert.svh
// assertion helpers, sampled on clk and held off while rst_n is low
`ifndef INTEGER_TO_ASCII_FIELD_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_FIELD_FORMATTER_CORE_ASSERT_SVH

// same-cycle implication
`define ITOA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/itoa_fmt_pkg.sv
package itoa_fmt_pkg;

    localparam int FIELD_CAPACITY_DEF = 32;
    localparam int DIGIT_DEPTH        = 20;
    localparam int IDX_W              = $clog2(DIGIT_DEPTH);
    localparam int STEP_W             = 7;

    localparam logic [1:0] CMD_SIGNED_DEC   = 2'd0;
    localparam logic [1:0] CMD_UNSIGNED_DEC = 2'd1;
    localparam logic [1:0] CMD_HEX          = 2'd2;
    localparam int         CMD_HEX_BIT      = 1;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] value;
        logic        wide;
        logic [5:0]  field_width;
        logic        zero_fill;
    } in_item_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic scan_step;
        logic setup;
        logic emit_step;
    } dp_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic scan_done;
        logic out_free;
        logic emit_last;
    } dp_status_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < 4'd10)
        begin
            return CHAR_ZERO + {4'd0, d};
        end
        return CHAR_UPPER + {4'd0, d - 4'd10};
    endfunction

endpackage

// File: hw/rtl/itoa_fmt_dp.sv
module itoa_fmt_dp #(
    parameter int FIELD_CAPACITY = itoa_fmt_pkg::FIELD_CAPACITY_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  itoa_fmt_pkg::in_item_t  item,
    input  itoa_fmt_pkg::dp_cmd_t   cmd,
    output itoa_fmt_pkg::dp_status_t stat,
    output logic                    result_valid,
    input  logic                    result_stall,
    output itoa_fmt_pkg::out_item_t result
);
    import itoa_fmt_pkg::*;

    localparam int LEN_MAX = (FIELD_CAPACITY > DIGIT_DEPTH + 1) ? FIELD_CAPACITY
                                                                : DIGIT_DEPTH + 1;
    localparam int LEN_W   = $clog2(LEN_MAX + 1);

    logic [63:0]        shift_reg, shift_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [3:0]         digit_reg [DIGIT_DEPTH];
    logic [3:0]         digit_next [DIGIT_DEPTH];
    logic [3:0]         adj [DIGIT_DEPTH];
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               neg_reg, neg_next;
    logic               zf_reg, zf_next;
    logic [LEN_W-1:0]   fw_reg, fw_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic               result_valid_reg, result_valid_next;
    out_item_t          result_reg, result_next;

    logic [63:0]                value_in;
    logic                       sign_bit;
    logic                       neg_in;
    logic [63:0]                mag_raw;
    logic [63:0]                mag;
    logic [4*DIGIT_DEPTH-1:0]   hex_word;
    logic [LEN_W-1:0]           natural;
    logic [LEN_W-1:0]           count;
    logic [LEN_W-1:0]           rem;
    logic                       is_digit;
    logic [7:0]                 ch;

    // operand sign and magnitude
    always_comb
    begin
        value_in = item.wide ? item.value : {32'd0, item.value[31:0]};
        sign_bit = item.wide ? item.value[63] : item.value[31];
        neg_in   = (item.command == CMD_SIGNED_DEC) && sign_bit;
        mag_raw  = neg_in ? (64'd0 - value_in) : value_in;
        mag      = item.wide ? mag_raw : {32'd0, mag_raw[31:0]};
        hex_word = (4*DIGIT_DEPTH)'(mag);
    end

    always_comb
    begin
        for (int i = 0; i < DIGIT_DEPTH; i++)
        begin
            adj[i] = (digit_reg[i] >= 4'd5) ? digit_reg[i] + 4'd3 : digit_reg[i];
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        step_next  = step_reg;
        digit_next = digit_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        zf_next    = zf_reg;
        fw_next    = fw_reg;
        if (cmd.load)
        begin
            shift_next = item.wide ? mag : {mag[31:0], 32'd0};
            if (item.command[CMD_HEX_BIT])
            begin
                step_next = '0;
            end
            else
            begin
                step_next = item.wide ? STEP_W'(64) : STEP_W'(32);
            end
            for (int i = 0; i < DIGIT_DEPTH; i++)
            begin
                digit_next[i] = item.command[CMD_HEX_BIT] ? hex_word[4*i +: 4] : 4'd0;
            end
            idx_next = IDX_W'(DIGIT_DEPTH - 1);
            neg_next = neg_in;
            zf_next  = item.zero_fill;
            fw_next  = (32'(item.field_width) > FIELD_CAPACITY) ? LEN_W'(FIELD_CAPACITY)
                                                                : LEN_W'(item.field_width);
        end
        else if (cmd.conv_step)
        begin
            // shift-and-add-3 step across all bcd digits
            shift_next    = {shift_reg[62:0], 1'b0};
            step_next     = step_reg - STEP_W'(1);
            digit_next[0] = {adj[0][2:0], shift_reg[63]};
            for (int i = 1; i < DIGIT_DEPTH; i++)
            begin
                digit_next[i] = {adj[i][2:0], adj[i-1][3]};
            end
        end
        else if (cmd.scan_step)
        begin
            idx_next = idx_reg - IDX_W'(1);
        end
    end

    // field geometry: total length is max(width, natural), head cut when too long
    always_comb
    begin
        count    = LEN_W'(idx_reg) + LEN_W'(1);
        natural  = count + LEN_W'(neg_reg);
        len_next = len_reg;
        pos_next = pos_reg;
        if (cmd.setup)
        begin
            len_next = (fw_reg > natural) ? fw_reg : natural;
            pos_next = ((fw_reg != '0) && (natural > fw_reg)) ? natural - fw_reg : '0;
        end
        else if (cmd.emit_step)
        begin
            pos_next = pos_reg + LEN_W'(1);
        end
    end

    // character at the current position, counted from the right end
    always_comb
    begin
        rem      = len_reg - LEN_W'(1) - pos_reg;
        is_digit = rem < count;
        if (is_digit)
        begin
            ch = digit_char(digit_reg[rem[IDX_W-1:0]]);
        end
        else if (zf_reg)
        begin
            ch = (neg_reg && (pos_reg == '0)) ? CHAR_MINUS : CHAR_ZERO;
        end
        else
        begin
            ch = (neg_reg && (rem == count)) ? CHAR_MINUS : CHAR_SPACE;
        end
    end

    always_comb
    begin
        result_next = result_reg;
        if (cmd.emit_step)
        begin
            result_valid_next     = 1'b1;
            result_next.character = ch;
            result_next.last      = stat.emit_last;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_comb
    begin
        stat.conv_done = (step_reg == '0);
        stat.scan_done = (idx_reg == '0) || (digit_reg[idx_reg] != 4'd0);
        stat.out_free  = !result_valid_reg || !result_stall;
        stat.emit_last = (pos_reg == len_reg - LEN_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            step_reg         <= '0;
            idx_reg          <= '0;
            len_reg          <= '0;
            pos_reg          <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            step_reg         <= step_next;
            idx_reg          <= idx_next;
            len_reg          <= len_next;
            pos_reg          <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg  <= shift_next;
        digit_reg  <= digit_next;
        neg_reg    <= neg_next;
        zf_reg     <= zf_next;
        fw_reg     <= fw_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: hw/rtl/itoa_fmt_ctrl.sv
module itoa_fmt_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  itoa_fmt_pkg::dp_status_t stat,
    output itoa_fmt_pkg::dp_cmd_t    cmd
);
    import itoa_fmt_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SETUP = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = item_valid;
                if (item_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = !stat.conv_done;
                if (stat.conv_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // drop leading zero digits, keeping at least one
                cmd.scan_step = !stat.scan_done;
                if (stat.scan_done)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_step = stat.out_free;
                if (stat.out_free && stat.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != ST_IDLE);

endmodule

// File: hw/rtl/integer_to_ascii_field_formatter_core.sv
// Integer to ASCII field formatter.
// Input channel item/item_valid/item_stall carries one integer with its
// conversion kind, 32/64-bit size, field width and zero-fill flag; a
// transaction happens when item_valid is high and item_stall is low.
// Output channel result/result_valid/result_stall delivers one character per
// transaction, most significant first, with last set on the final one.
// An item runs through the controller states in order: idle accepts and loads
// the operand, then the shift-and-add-3 converter runs one operand bit per cycle
// over 32 or 64 bits (no shifts for hex), a leading-zero scan drops leading zero
// digits, a setup state computes the field geometry, then emission sends one
// character per unstalled cycle through the output register.
// item_stall stays high until the last character is in the output register,
// so the next item is taken while that character still waits.
// A stalled output holds its character and pauses emission.
// Reset clears the controller and the output valid flag; no result is pending.
`include "integer_to_ascii_field_formatter_core_assert.svh"

module integer_to_ascii_field_formatter_core #(
    parameter int FIELD_CAPACITY = itoa_fmt_pkg::FIELD_CAPACITY_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  itoa_fmt_pkg::in_item_t  item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output itoa_fmt_pkg::out_item_t result
);
    import itoa_fmt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    itoa_fmt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    itoa_fmt_dp #(
        .FIELD_CAPACITY (FIELD_CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `ITOA_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall,
        "no stall after an accepted item")
    `ITOA_ASSERT_NEXT(a_idle_after_last, cmd.emit_step && stat.emit_last, !item_stall,
        "still busy after the last character")
    `ITOA_ASSERT_IMPL(a_idle_holds_last, !item_stall && result_valid, result.last,
        "idle with a non-final character pending")

endmodule

// File: tb/sv/integer_to_ascii_field_formatter_core_tb.sv
module integer_to_ascii_field_formatter_core_tb;

    import itoa_fmt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 190;
    localparam int CALM_FROM = 150;

    // command three decodes as hex
    localparam logic [1:0] CMD_HEX_ALIAS = 2'd3;

    class field_text_checker;
        out_item_t pending_chars[$];
        int fail_count = 0;

        // builds the expected character stream for one accepted number
        function void note_number(in_item_t it);
            logic [63:0] mag;
            logic [3:0]  digit;
            logic [7:0]  digits[$];
            logic [7:0]  text[$];
            out_item_t   exp_char;
            bit          neg;
            int          field_len;
            int          natural_len;
            int          pad;
            int          first;
            int          count;
            int          i;

            mag = it.wide ? it.value : {32'd0, it.value[31:0]};
            neg = 1'b0;
            if (it.command == CMD_SIGNED_DEC && (it.wide ? mag[63] : mag[31]))
            begin
                neg = 1'b1;
                mag = -mag;
                if (!it.wide)
                begin
                    mag[63:32] = 32'd0;
                end
            end

            do
            begin
                if (it.command[CMD_HEX_BIT])
                begin
                    digit = mag[3:0];
                    mag = mag >> 4;
                end
                else
                begin
                    digit = 4'(mag % 64'd10);
                    mag = mag / 64'd10;
                end
                digits.push_front((digit < 4'd10) ? CHAR_ZERO + 8'(digit)
                                                  : CHAR_UPPER + 8'(digit) - 8'd10);
            end
            while (mag != 64'd0 && digits.size() < DIGIT_DEPTH);

            field_len = (it.field_width > FIELD_CAPACITY_DEF) ? FIELD_CAPACITY_DEF
                                                              : int'(it.field_width);
            natural_len = digits.size() + (neg ? 1 : 0);
            pad = (field_len > natural_len) ? field_len - natural_len : 0;

            // spaces go before the sign, zeros after it
            if (!it.zero_fill)
            begin
                for (i = 0; i < pad; i++)
                begin
                    text.push_back(CHAR_SPACE);
                end
            end
            if (neg)
            begin
                text.push_back(CHAR_MINUS);
            end
            if (it.zero_fill)
            begin
                for (i = 0; i < pad; i++)
                begin
                    text.push_back(CHAR_ZERO);
                end
            end
            foreach (digits[j])
            begin
                text.push_back(digits[j]);
            end

            // keep the rightmost characters when the text overflows the width
            count = text.size();
            first = 0;
            if (field_len != 0 && count > field_len)
            begin
                first = count - field_len;
                count = field_len;
            end
            for (i = 0; i < count; i++)
            begin
                exp_char.character = text[first + i];
                exp_char.last = (i == count - 1);
                pending_chars.push_back(exp_char);
            end
        endfunction

        function void check_char(out_item_t got);
            out_item_t exp_char;

            if (pending_chars.size() == 0)
            begin
                $error("unexpected character transaction: character %h last %b",
                       got.character, got.last);
                fail_count++;
                return;
            end
            exp_char = pending_chars.pop_front();
            if (got.character !== exp_char.character)
            begin
                $error("character: expected %h, got %h", exp_char.character, got.character);
                fail_count++;
            end
            if (got.last !== exp_char.last)
            begin
                $error("last: expected %b, got %b", exp_char.last, got.last);
                fail_count++;
            end
        endfunction

        function int pending_count();
            return pending_chars.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    field_text_checker chk = new();
    bit idle_on = 1'b1;
    bit hold_off_req = 1'b0;
    int quiet_cycles = 0;

    integer_to_ascii_field_formatter_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                chk.note_number(item);
            end
            if (result_valid && !result_stall)
            begin
                chk.check_char(result);
            end
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("integer_to_ascii_field_formatter_core regression: fail");
                $finish;
            end
        end
    end

    // receiver: random stall bursts plus one long hold-off
    initial
    begin
        int stall_left;

        stall_left = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    function automatic in_item_t make_item(logic [1:0] cmd, logic [63:0] value, logic wide,
                                           logic [5:0] width, logic zero_fill);
        in_item_t it;

        it.command = cmd;
        it.value = value;
        it.wide = wide;
        it.field_width = width;
        it.zero_fill = zero_fill;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int pick;

        pick = $urandom_range(0, 9);
        it.command = (pick < 3) ? CMD_SIGNED_DEC : (pick < 6) ? CMD_UNSIGNED_DEC :
                     (pick < 9) ? CMD_HEX : CMD_HEX_ALIAS;
        case ($urandom_range(0, 5))
            0: it.value = {$urandom, 32'(int'($urandom_range(0, 999)))};
            1: it.value = {$urandom, $urandom};
            2: it.value = {$urandom, 32'hffff_ff00 | 32'($urandom_range(0, 255))};
            3: it.value = {32'h8000_0000 | 32'($urandom_range(0, 3)), $urandom};
            4: it.value = {$urandom, 32'h8000_0000 | 32'($urandom_range(0, 3))};
            default: it.value = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        it.wide = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 19);
        it.field_width = (pick < 4) ? 6'd0 : (pick < 18) ? 6'($urandom_range(1, 32))
                                                        : 6'($urandom_range(33, 63));
        it.zero_fill = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // offers one transaction; entered and left at a falling edge
    task automatic send_number(in_item_t it);
        int gap;

        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
        begin
            @(posedge clk);
        end
        while (item_stall !== 1'b0);
        @(negedge clk);
    endtask

    initial
    begin
        in_item_t directed[$];
        int k;

        item_valid = 1'b0;
        item = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed.push_back(make_item(CMD_SIGNED_DEC, 64'd0, 1'b0, 6'd0, 1'b0));
        directed.push_back(make_item(CMD_SIGNED_DEC, 64'h0000_0000_8000_0000, 1'b0, 6'd0, 1'b0));
        directed.push_back(make_item(CMD_SIGNED_DEC, 64'h8000_0000_0000_0000, 1'b1, 6'd0, 1'b0));
        directed.push_back(make_item(CMD_SIGNED_DEC, 64'h7fff_ffff_ffff_ffff, 1'b1, 6'd0, 1'b0));
        directed.push_back(make_item(CMD_SIGNED_DEC, 64'h1234_5678_7fff_ffff, 1'b0, 6'd0, 1'b1));
        directed.push_back(make_item(CMD_SIGNED_DEC, {64{1'b1}}, 1'b1, 6'd0, 1'b0));
        directed.push_back(make_item(CMD_UNSIGNED_DEC, {64{1'b1}}, 1'b1, 6'd0, 1'b0));
        directed.push_back(make_item(CMD_UNSIGNED_DEC, {64{1'b1}}, 1'b0, 6'd12, 1'b1));
        directed.push_back(make_item(CMD_UNSIGNED_DEC, 64'd0, 1'b1, 6'd5, 1'b1));
        directed.push_back(make_item(CMD_HEX, {64{1'b1}}, 1'b1, 6'd0, 1'b0));
        directed.push_back(make_item(CMD_HEX_ALIAS, 64'hcafe_f00d_dead_beef, 1'b0, 6'd0, 1'b0));
        directed.push_back(make_item(CMD_HEX_ALIAS, 64'h0123_4567_89ab_cdef, 1'b1, 6'd20, 1'b1));
        // minus sign ahead of zero fill, spaces ahead of the minus sign
        directed.push_back(make_item(CMD_SIGNED_DEC, 64'hffff_ffff, 1'b0, 6'd8, 1'b1));
        directed.push_back(make_item(CMD_SIGNED_DEC, 64'hffff_ffff, 1'b0, 6'd8, 1'b0));
        // truncation drops the minus sign
        directed.push_back(make_item(CMD_SIGNED_DEC, -64'sd12345, 1'b1, 6'd3, 1'b0));
        directed.push_back(make_item(CMD_SIGNED_DEC, -64'sd12345, 1'b1, 6'd6, 1'b1));
        directed.push_back(make_item(CMD_HEX, 64'h0000_0000_0000_abcd, 1'b0, 6'd1, 1'b0));
        // widths past capacity saturate
        directed.push_back(make_item(CMD_SIGNED_DEC, 64'd42, 1'b0, 6'd63, 1'b1));
        directed.push_back(make_item(CMD_UNSIGNED_DEC, 64'd42, 1'b0, 6'd33, 1'b0));
        directed.push_back(make_item(CMD_SIGNED_DEC, 64'h8000_0000_0000_0000, 1'b1, 6'd32, 1'b1));
        directed.push_back(make_item(CMD_UNSIGNED_DEC, 64'd1234567, 1'b0, 6'd7, 1'b0));
        directed.push_back(make_item(CMD_HEX, 64'd0, 1'b1, 6'd32, 1'b0));

        foreach (directed[j])
        begin
            send_number(directed[j]);
        end

        // long receiver hold-off while items keep coming
        hold_off_req = 1'b1;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == CALM_FROM)
            begin
                idle_on = 1'b0;
            end
            send_number(random_item());
        end
        item_valid <= 1'b0;

        while (chk.pending_count() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (chk.fail_count == 0 && chk.pending_count() == 0)
        begin
            $display("integer_to_ascii_field_formatter_core regression: pass");
        end
        else
        begin
            $display("integer_to_ascii_field_formatter_core regression: fail");
        end
        $finish;
    end

endmodule
